[sv/sdst_pkg.sv]
`timescale 1ns / 1ps
// Shared types, constants and helpers for the spring-damper substep tracker.
// Depends on nothing; every other file of the block uses it by scoped names.
package sdst_pkg;

  // Fixed field widths
  localparam int Q_W          = 32;
  localparam int CMD_W        = 2;
  localparam int SPRING_W     = 27;
  localparam int DAMP_W       = 23;
  localparam int CFG_W        = 32;
  localparam int CFG_IDX_W    = 2;

  // Time base: substep length in ticks of 2^-20 s, elapsed field width
  localparam int SUBSTEP_TICKS = 5243;
  localparam int ELAPSED_BITS  = 20;
  localparam int TIME_FRAC     = 20;
  localparam int Q_FRAC        = 16;
  localparam int TICK_W        = $clog2(SUBSTEP_TICKS + 1);
  localparam int CMP_W         = (ELAPSED_BITS > TICK_W) ? ELAPSED_BITS : TICK_W;

  // Shared multiplier: one extra bit for the position difference
  localparam int MUL_W  = Q_W + 1;
  localparam int PROD_W = 2 * MUL_W;

  // Register reset values
  localparam logic [SPRING_W-1:0] SPRING_RST = SPRING_W'(655360);
  localparam logic [DAMP_W-1:0]   DAMP_RST   = DAMP_W'(414487);
  localparam logic [Q_W-1:0]      SCALE_RST  = Q_W'(65536);

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_SPRING = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DAMP   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SCALE  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_FORCE  = 2'd3;

  // Command codes
  localparam logic [CMD_W-1:0] CMD_UPDATE   = 2'd0;
  localparam logic [CMD_W-1:0] CMD_ZERO_VEL = 2'd1;
  localparam logic [CMD_W-1:0] CMD_ACTIVATE = 2'd2;

  // Sequencer states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DEST_MUL,
    ST_DEST_SAT,
    ST_DIFF,
    ST_MUL_K,
    ST_MUL_D,
    ST_ACCEL,
    ST_MUL_A,
    ST_VEL,
    ST_MUL_V,
    ST_POS,
    ST_DONE
  } state_t;

  // Multiplier operand selection
  typedef enum logic [2:0] {
    OP_DEST,
    OP_K,
    OP_D,
    OP_A,
    OP_V
  } opsel_t;

  // Per-state control word
  typedef struct packed {
    logic   ready;
    logic   mul_en;
    opsel_t opsel;
  } ctrl_t;

  // Clamp a wide signed value to the signed Q16.16 range
  function automatic logic signed [Q_W-1:0] sat_q(input logic signed [PROD_W-1:0] v);
    logic [PROD_W-Q_W:0] top;
    logic signed [Q_W-1:0] res;
    top = v[PROD_W-1:Q_W-1];
    if ((top == '0) || (top == '1)) begin
      res = v[Q_W-1:0];
    end else if (v[PROD_W-1]) begin
      res = {1'b1, {(Q_W-1){1'b0}}};
    end else begin
      res = {1'b0, {(Q_W-1){1'b1}}};
    end
    return res;
  endfunction

endpackage

[sv/sdst_req_if.sv]
`timescale 1ns / 1ps
// Command channel of the tracker: valid/ready plus one command word.
// Depends on sdst_pkg for field widths.
interface sdst_req_if;
  logic                              valid;
  logic                              ready;
  logic [sdst_pkg::CMD_W-1:0]        cmd;
  logic signed [sdst_pkg::Q_W-1:0]   target;
  logic [sdst_pkg::ELAPSED_BITS-1:0] elapsed;

  modport source (output valid, cmd, target, elapsed, input ready);
  modport sink   (input valid, cmd, target, elapsed, output ready);
endinterface

[sv/sdst_rsp_if.sv]
`timescale 1ns / 1ps
// Result channel of the tracker: valid/ready plus position and speed.
// Depends on sdst_pkg for field widths.
interface sdst_rsp_if;
  logic                            valid;
  logic                            ready;
  logic signed [sdst_pkg::Q_W-1:0] position;
  logic signed [sdst_pkg::Q_W-1:0] speed;

  modport source (output valid, position, speed, input ready);
  modport sink   (input valid, position, speed, output ready);
endinterface

[sv/sdst_mul.sv]
`timescale 1ns / 1ps
// Shared signed multiplier with a registered product.
// Depends on sdst_pkg for operand and product widths.
module sdst_mul (
  input  logic                               clk,
  input  logic                               en,
  input  logic signed [sdst_pkg::MUL_W-1:0]  a,
  input  logic signed [sdst_pkg::MUL_W-1:0]  b,
  output logic signed [sdst_pkg::PROD_W-1:0] prod
);

  // Capture the full product when enabled, hold otherwise
  always_ff @(posedge clk) begin
    if (en) begin
      prod <= a * b;
    end
  end

endmodule

[sv/spring_damper_substep_tracker.sv]
`timescale 1ns / 1ps
// Spring-damper tracker, Q16.16, one shared multiplier under a sequencer.
// Update: floor(elapsed/5243)+1 steps through DIFF, MUL_K, MUL_D, ACCEL, MUL_A, VEL,
// MUL_V and POS after setup in DEST_MUL and DEST_SAT; the result loads in DONE.
// One command at a time: the next word is taken once the sequencer is idle again.
// Synchronous reset restores register defaults and clears position and velocity.
module spring_damper_substep_tracker (
  input  logic                                clk,
  input  logic                                rst,
  sdst_req_if.sink                            req,
  sdst_rsp_if.source                          rsp,
  input  logic                                cfg_we,
  input  logic [sdst_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [sdst_pkg::CFG_W-1:0]          cfg_data
);

  localparam logic signed [sdst_pkg::PROD_W-1:0] HALF_Q =
    sdst_pkg::PROD_W'(2 ** (sdst_pkg::Q_FRAC - 1));
  localparam logic signed [sdst_pkg::PROD_W-1:0] HALF_T =
    sdst_pkg::PROD_W'(2 ** (sdst_pkg::TIME_FRAC - 1));
  localparam logic [sdst_pkg::CMP_W-1:0] STEP_CMP =
    sdst_pkg::CMP_W'(sdst_pkg::SUBSTEP_TICKS);

  // Configuration registers
  logic [sdst_pkg::SPRING_W-1:0]   spring;
  logic [sdst_pkg::DAMP_W-1:0]     damp;
  logic signed [sdst_pkg::Q_W-1:0] scale;
  logic                            force_act;

  // Tracker state and working registers
  sdst_pkg::state_t                state, state_next;
  sdst_pkg::ctrl_t                 ctrl;
  logic signed [sdst_pkg::Q_W-1:0] pos;
  logic signed [sdst_pkg::Q_W-1:0] vel;
  logic [sdst_pkg::CMD_W-1:0]      cmd_hold;
  logic signed [sdst_pkg::Q_W-1:0] tgt;
  logic [sdst_pkg::ELAPSED_BITS-1:0] rem_ticks;
  logic [sdst_pkg::TICK_W-1:0]     ticks;
  logic                            last;
  logic signed [sdst_pkg::Q_W-1:0] dest;
  logic signed [sdst_pkg::MUL_W-1:0] diff;
  logic signed [sdst_pkg::PROD_W-1:0] acc;
  logic signed [sdst_pkg::Q_W-1:0] accel;
  logic                            out_valid;
  logic signed [sdst_pkg::Q_W-1:0] out_pos;
  logic signed [sdst_pkg::Q_W-1:0] out_vel;

  // Datapath helpers
  logic signed [sdst_pkg::MUL_W-1:0]  mul_a;
  logic signed [sdst_pkg::MUL_W-1:0]  mul_b;
  logic signed [sdst_pkg::PROD_W-1:0] prod;
  logic [sdst_pkg::CMP_W-1:0]         rem_ext;
  logic                               take;
  logic                               load_out;

  // Take no word while reset is held
  assign take     = req.valid && ctrl.ready && !rst;
  assign load_out = (state == sdst_pkg::ST_DONE) && (!out_valid || rsp.ready);
  assign rem_ext  = sdst_pkg::CMP_W'(rem_ticks);

  // Write configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      spring    <= sdst_pkg::SPRING_RST;
      damp      <= sdst_pkg::DAMP_RST;
      scale     <= sdst_pkg::SCALE_RST;
      force_act <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        sdst_pkg::REG_SPRING: spring    <= cfg_data[sdst_pkg::SPRING_W-1:0];
        sdst_pkg::REG_DAMP:   damp      <= cfg_data[sdst_pkg::DAMP_W-1:0];
        sdst_pkg::REG_SCALE:  scale     <= cfg_data[sdst_pkg::Q_W-1:0];
        sdst_pkg::REG_FORCE:  force_act <= cfg_data[0];
      endcase
    end
  end

  // Advance the sequencer
  always_comb begin
    state_next = state;
    unique case (state)
      sdst_pkg::ST_IDLE: begin
        if (take) begin
          state_next = (req.cmd == sdst_pkg::CMD_UPDATE) ? sdst_pkg::ST_DEST_MUL
                                                         : sdst_pkg::ST_DONE;
        end
      end
      sdst_pkg::ST_DEST_MUL: state_next = sdst_pkg::ST_DEST_SAT;
      sdst_pkg::ST_DEST_SAT: state_next = sdst_pkg::ST_DIFF;
      sdst_pkg::ST_DIFF:     state_next = sdst_pkg::ST_MUL_K;
      sdst_pkg::ST_MUL_K:    state_next = sdst_pkg::ST_MUL_D;
      sdst_pkg::ST_MUL_D:    state_next = sdst_pkg::ST_ACCEL;
      sdst_pkg::ST_ACCEL:    state_next = sdst_pkg::ST_MUL_A;
      sdst_pkg::ST_MUL_A:    state_next = sdst_pkg::ST_VEL;
      sdst_pkg::ST_VEL:      state_next = sdst_pkg::ST_MUL_V;
      sdst_pkg::ST_MUL_V:    state_next = sdst_pkg::ST_POS;
      sdst_pkg::ST_POS:      state_next = last ? sdst_pkg::ST_DONE : sdst_pkg::ST_DIFF;
      sdst_pkg::ST_DONE: begin
        if (load_out) begin
          state_next = sdst_pkg::ST_IDLE;
        end
      end
      default:               state_next = sdst_pkg::ST_IDLE;
    endcase
  end

  // Drive per-state controls
  always_comb begin
    ctrl.ready  = 1'b0;
    ctrl.mul_en = 1'b0;
    ctrl.opsel  = sdst_pkg::OP_DEST;
    unique case (state)
      sdst_pkg::ST_IDLE:     ctrl.ready = 1'b1;
      sdst_pkg::ST_DEST_MUL: begin
        ctrl.mul_en = 1'b1;
        ctrl.opsel  = sdst_pkg::OP_DEST;
      end
      sdst_pkg::ST_MUL_K: begin
        ctrl.mul_en = 1'b1;
        ctrl.opsel  = sdst_pkg::OP_K;
      end
      sdst_pkg::ST_MUL_D: begin
        ctrl.mul_en = 1'b1;
        ctrl.opsel  = sdst_pkg::OP_D;
      end
      sdst_pkg::ST_MUL_A: begin
        ctrl.mul_en = 1'b1;
        ctrl.opsel  = sdst_pkg::OP_A;
      end
      sdst_pkg::ST_MUL_V: begin
        ctrl.mul_en = 1'b1;
        ctrl.opsel  = sdst_pkg::OP_V;
      end
      default: ctrl.ready = 1'b0;
    endcase
  end

  // Select multiplier operands
  always_comb begin
    unique case (ctrl.opsel)
      sdst_pkg::OP_DEST: begin
        mul_a = sdst_pkg::MUL_W'(scale);
        mul_b = sdst_pkg::MUL_W'(tgt);
      end
      sdst_pkg::OP_K: begin
        mul_a = diff;
        mul_b = sdst_pkg::MUL_W'(spring);
      end
      sdst_pkg::OP_D: begin
        mul_a = sdst_pkg::MUL_W'(vel);
        mul_b = sdst_pkg::MUL_W'(damp);
      end
      sdst_pkg::OP_A: begin
        mul_a = sdst_pkg::MUL_W'(accel);
        mul_b = sdst_pkg::MUL_W'(ticks);
      end
      sdst_pkg::OP_V: begin
        mul_a = sdst_pkg::MUL_W'(vel);
        mul_b = sdst_pkg::MUL_W'(ticks);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  sdst_mul u_mul (
    .clk  (clk),
    .en   (ctrl.mul_en),
    .a    (mul_a),
    .b    (mul_b),
    .prod (prod)
  );

  // Sequencer state, position and velocity
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= sdst_pkg::ST_IDLE;
      pos   <= '0;
      vel   <= '0;
    end else begin
      state <= state_next;
      if ((state == sdst_pkg::ST_DONE) && (cmd_hold == sdst_pkg::CMD_ZERO_VEL)) begin
        vel <= '0;
      end
      if ((state == sdst_pkg::ST_DONE) && (cmd_hold == sdst_pkg::CMD_ACTIVATE) &&
          force_act) begin
        pos <= tgt;
      end
      if (state == sdst_pkg::ST_VEL) begin
        vel <= sdst_pkg::sat_q((prod + (sdst_pkg::PROD_W'(vel) <<< sdst_pkg::TIME_FRAC)
                                + HALF_T) >>> sdst_pkg::TIME_FRAC);
      end
      if (state == sdst_pkg::ST_POS) begin
        pos <= sdst_pkg::sat_q((prod + (sdst_pkg::PROD_W'(pos) <<< sdst_pkg::TIME_FRAC)
                                + HALF_T) >>> sdst_pkg::TIME_FRAC);
      end
    end
  end

  // Working registers of one command
  always_ff @(posedge clk) begin
    if (take) begin
      cmd_hold  <= req.cmd;
      tgt       <= req.target;
      rem_ticks <= req.elapsed;
    end
    if (state == sdst_pkg::ST_DEST_SAT) begin
      dest <= sdst_pkg::sat_q((prod + HALF_Q) >>> sdst_pkg::Q_FRAC);
    end
    // Split off one whole substep, or the remainder as the final step
    if (state == sdst_pkg::ST_DIFF) begin
      diff <= sdst_pkg::MUL_W'(pos) - sdst_pkg::MUL_W'(dest);
      if (rem_ext >= STEP_CMP) begin
        ticks     <= sdst_pkg::TICK_W'(sdst_pkg::SUBSTEP_TICKS);
        rem_ticks <= sdst_pkg::ELAPSED_BITS'(rem_ext - STEP_CMP);
        last      <= 1'b0;
      end else begin
        ticks <= rem_ext[sdst_pkg::TICK_W-1:0];
        last  <= 1'b1;
      end
    end
    if (state == sdst_pkg::ST_MUL_D) begin
      acc <= HALF_Q - prod;
    end
    if (state == sdst_pkg::ST_ACCEL) begin
      accel <= sdst_pkg::sat_q((acc - prod) >>> sdst_pkg::Q_FRAC);
    end
  end

  // Hold the result word until the sink takes it
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  // Capture the reported state; zero-velocity and activate take effect here too
  always_ff @(posedge clk) begin
    if (load_out) begin
      out_pos <= ((cmd_hold == sdst_pkg::CMD_ACTIVATE) && force_act) ? tgt : pos;
      out_vel <= (cmd_hold == sdst_pkg::CMD_ZERO_VEL) ? '0 : vel;
    end
  end

  assign req.ready    = ctrl.ready && !rst;
  assign rsp.valid    = out_valid;
  assign rsp.position = out_pos;
  assign rsp.speed    = out_vel;

endmodule

[test/tb_spring_damper_substep_tracker.sv]
`timescale 1ns / 1ps
// Testbench for spring_damper_substep_tracker: directed and random command words,
// each result checked against a Q16.16 spring-damper predictor kept in the bench.
// Depends on sdst_pkg, sdst_req_if and sdst_rsp_if from the block's sources.
module tb_spring_damper_substep_tracker;

  localparam int CLK_PERIOD    = 4;
  localparam int RESET_CYCLES  = 7;
  localparam int PHASE_WORDS   = 50;
  localparam int RANDOM_PHASES = 10;
  localparam int EXTREME_WORDS = 12;
  localparam int PRESSURE_WORDS = 10;
  localparam int LONG_HOLD     = 400;
  localparam int GAP_BOUND     = 30;
  localparam int STALL_BOUND   = 64;
  localparam int ITEM_BOUND    = 640;
  // worst update: every whole substep plus the remainder step
  localparam int UPDATE_CYCLES =
    8 * ((2 ** sdst_pkg::ELAPSED_BITS) / sdst_pkg::SUBSTEP_TICKS + 1) + 3;
  localparam int CYCLE_LIMIT   =
    4 * ITEM_BOUND * (UPDATE_CYCLES + STALL_BOUND + GAP_BOUND) + 4 * LONG_HOLD;

  localparam logic [sdst_pkg::CMD_W-1:0]        CMD_UNUSED  = 2'd3;
  localparam logic signed [sdst_pkg::Q_W-1:0]   Q_ONE       = 32'sd65536;
  localparam logic signed [sdst_pkg::Q_W-1:0]   Q_POS_MAX   = 32'sh7fffffff;
  localparam logic signed [sdst_pkg::Q_W-1:0]   Q_NEG_MAX   = 32'sh80000000;
  localparam logic [sdst_pkg::ELAPSED_BITS-1:0] ELAPSED_MAX = '1;
  localparam longint                            SAT_HI      = 64'sd2147483647;
  localparam longint                            SAT_LO      = -64'sd2147483648;

  typedef struct packed {
    logic [sdst_pkg::CMD_W-1:0]        cmd;
    logic signed [sdst_pkg::Q_W-1:0]   target;
    logic [sdst_pkg::ELAPSED_BITS-1:0] elapsed;
  } tracker_word_t;

  typedef struct packed {
    logic signed [sdst_pkg::Q_W-1:0] position;
    logic signed [sdst_pkg::Q_W-1:0] speed;
  } tracker_state_t;

  typedef enum int {RX_OPEN, RX_COIN, RX_PATTERN, RX_MOSTLY} rx_mode_t;

  logic                           clk = 1'b0;
  logic                           rst;
  logic                           cfg_we;
  logic [sdst_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [sdst_pkg::CFG_W-1:0]     cfg_data;

  sdst_req_if req_ch();
  sdst_rsp_if rsp_ch();

  // Predictor state and its copy of the registers
  logic signed [sdst_pkg::Q_W-1:0] model_pos;
  logic signed [sdst_pkg::Q_W-1:0] model_vel;
  logic [sdst_pkg::SPRING_W-1:0]   model_k;
  logic [sdst_pkg::DAMP_W-1:0]     model_d;
  logic signed [sdst_pkg::Q_W-1:0] model_scale;
  logic                            model_force;

  tracker_state_t pending_states[$];
  tracker_state_t oldest_state;
  int             mismatch_count = 0;
  int             cycle_count = 0;
  int             burst_left = 0;
  int             hold_request = 0;
  int             hold_left = 0;
  int             mode_left = 0;
  int             pattern_pos = 0;
  rx_mode_t       stall_mode = RX_OPEN;
  logic [7:0]     stall_pattern = 8'hff;

  always #(CLK_PERIOD / 2) clk = ~clk;

  spring_damper_substep_tracker i_dut (
    .clk       (clk),
    .rst       (rst),
    .req       (req_ch),
    .rsp       (rsp_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // Clamp to the signed Q16.16 range
  function automatic logic signed [sdst_pkg::Q_W-1:0] clamp_q(input longint v);
    if (v > SAT_HI) return Q_POS_MAX;
    if (v < SAT_LO) return Q_NEG_MAX;
    return v[sdst_pkg::Q_W-1:0];
  endfunction

  // Drop shift bits, rounding to nearest with ties toward plus infinity
  function automatic longint round_q(input longint v, input int shift);
    return (v + (64'sd1 <<< (shift - 1))) >>> shift;
  endfunction

  // Advance the tracked state by one step of the given length in ticks
  function automatic void model_substep(input logic signed [sdst_pkg::Q_W-1:0] dest,
                                        input longint ticks);
    longint                          pull;
    logic signed [sdst_pkg::Q_W-1:0] accel;
    pull = -((longint'(model_pos) - longint'(dest)) * longint'(model_k))
           - longint'(model_vel) * longint'(model_d);
    accel = clamp_q(round_q(pull, sdst_pkg::Q_FRAC));
    model_vel = clamp_q(longint'(model_vel)
                        + round_q(longint'(accel) * ticks, sdst_pkg::TIME_FRAC));
    model_pos = clamp_q(longint'(model_pos)
                        + round_q(longint'(model_vel) * ticks, sdst_pkg::TIME_FRAC));
  endfunction

  // Apply one command word to the tracked state and report the new state
  function automatic tracker_state_t predict_word(input tracker_word_t w);
    logic signed [sdst_pkg::Q_W-1:0] dest;
    int                              whole;
    tracker_state_t                  r;
    case (w.cmd)
      sdst_pkg::CMD_UPDATE: begin
        dest = clamp_q(round_q(longint'(model_scale) * longint'($signed(w.target)),
                               sdst_pkg::Q_FRAC));
        whole = w.elapsed / sdst_pkg::SUBSTEP_TICKS;
        for (int i = 0; i < whole; i++) begin
          model_substep(dest, longint'(sdst_pkg::SUBSTEP_TICKS));
        end
        model_substep(dest, longint'(w.elapsed % sdst_pkg::SUBSTEP_TICKS));
      end
      sdst_pkg::CMD_ZERO_VEL: model_vel = '0;
      sdst_pkg::CMD_ACTIVATE: begin
        if (model_force) model_pos = w.target;
      end
      default: ;
    endcase
    r.position = model_pos;
    r.speed = model_vel;
    return r;
  endfunction

  function automatic tracker_word_t word_of(input logic [sdst_pkg::CMD_W-1:0] cmd,
                                            input logic [sdst_pkg::Q_W-1:0] target,
                                            input logic [sdst_pkg::ELAPSED_BITS-1:0] elapsed);
    tracker_word_t w;
    w.cmd = cmd;
    w.target = target;
    w.elapsed = elapsed;
    return w;
  endfunction

  // Mostly updates near a setpoint with short elapsed times, some long ones
  function automatic tracker_word_t random_word(input logic signed [sdst_pkg::Q_W-1:0] setpoint);
    int unsigned   pick;
    tracker_word_t w;
    pick = $urandom_range(0, 99);
    if (pick < 70) w.cmd = sdst_pkg::CMD_UPDATE;
    else if (pick < 80) w.cmd = sdst_pkg::CMD_ZERO_VEL;
    else if (pick < 92) w.cmd = sdst_pkg::CMD_ACTIVATE;
    else w.cmd = CMD_UNUSED;
    pick = $urandom_range(0, 9);
    if (pick < 5) w.target = setpoint + sdst_pkg::Q_W'($urandom_range(0, 131072)) - Q_ONE;
    else if (pick < 8) w.target = $urandom;
    else if (pick == 8) w.target = Q_POS_MAX;
    else w.target = Q_NEG_MAX;
    pick = $urandom_range(0, 99);
    if (pick < 45) begin
      w.elapsed = sdst_pkg::ELAPSED_BITS'($urandom_range(0, sdst_pkg::SUBSTEP_TICKS));
    end else if (pick < 75) begin
      w.elapsed = sdst_pkg::ELAPSED_BITS'($urandom_range(sdst_pkg::SUBSTEP_TICKS,
                                                         4 * sdst_pkg::SUBSTEP_TICKS));
    end else if (pick < 88) begin
      w.elapsed = sdst_pkg::ELAPSED_BITS'($urandom);
    end else if (pick < 93) begin
      w.elapsed = ELAPSED_MAX;
    end else begin
      w.elapsed = sdst_pkg::ELAPSED_BITS'($urandom_range(0, 3) * sdst_pkg::SUBSTEP_TICKS
                                          + $urandom_range(0, 1));
    end
    return w;
  endfunction

  // Offer one word, hold it until taken, then log its expected result
  task automatic send_word(input tracker_word_t w);
    req_ch.valid <= 1'b1;
    req_ch.cmd <= w.cmd;
    req_ch.target <= w.target;
    req_ch.elapsed <= w.elapsed;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    pending_states.push_back(predict_word(w));
    // end the burst with a random gap
    if (burst_left > 0) burst_left--;
    if (burst_left == 0) begin
      req_ch.valid <= 1'b0;
      repeat (($urandom_range(0, 3) == 0) ? $urandom_range(10, GAP_BOUND)
                                          : $urandom_range(1, 4)) @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(10, 24)
                                               : $urandom_range(1, 6);
    end
  endtask

  task automatic run_words(input int count, input logic signed [sdst_pkg::Q_W-1:0] setpoint);
    repeat (count) send_word(random_word(setpoint));
  endtask

  // Stop offering words until every expected result is back
  task automatic wait_for_results();
    req_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending_states.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic [sdst_pkg::CFG_IDX_W-1:0] idx,
                           input logic [sdst_pkg::CFG_W-1:0] data);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      sdst_pkg::REG_SPRING: model_k = data[sdst_pkg::SPRING_W-1:0];
      sdst_pkg::REG_DAMP:   model_d = data[sdst_pkg::DAMP_W-1:0];
      sdst_pkg::REG_SCALE:  model_scale = data;
      sdst_pkg::REG_FORCE:  model_force = data[0];
      default: ;
    endcase
  endtask

  task automatic apply_setting(input logic [sdst_pkg::CFG_W-1:0] k_val,
                               input logic [sdst_pkg::CFG_W-1:0] d_val,
                               input logic [sdst_pkg::CFG_W-1:0] scale_val,
                               input logic [sdst_pkg::CFG_W-1:0] force_val);
    wait_for_results();
    write_reg(sdst_pkg::REG_SPRING, k_val);
    write_reg(sdst_pkg::REG_DAMP, d_val);
    write_reg(sdst_pkg::REG_SCALE, scale_val);
    write_reg(sdst_pkg::REG_FORCE, force_val);
  endtask

  // Field extremes, every command, zero-tick remainder, activate with and without force
  task automatic test_directed_words();
    send_word(word_of(sdst_pkg::CMD_UPDATE, '0, '0));
    send_word(word_of(sdst_pkg::CMD_UPDATE, 4 * Q_ONE,
                      sdst_pkg::ELAPSED_BITS'(sdst_pkg::SUBSTEP_TICKS)));
    send_word(word_of(sdst_pkg::CMD_UPDATE, Q_POS_MAX,
                      sdst_pkg::ELAPSED_BITS'(sdst_pkg::SUBSTEP_TICKS - 1)));
    send_word(word_of(sdst_pkg::CMD_UPDATE, Q_NEG_MAX, ELAPSED_MAX));
    send_word(word_of(sdst_pkg::CMD_UPDATE, Q_POS_MAX, ELAPSED_MAX));
    send_word(word_of(sdst_pkg::CMD_ZERO_VEL, 32'h55555555, 20'h55555));
    send_word(word_of(sdst_pkg::CMD_ACTIVATE, 32'h12345678, '0));
    send_word(word_of(CMD_UNUSED, 32'haaaaaaaa, 20'haaaaa));
    send_word(word_of(sdst_pkg::CMD_UPDATE, -Q_ONE, 20'd1));
    send_word(word_of(sdst_pkg::CMD_UPDATE, '0,
                      sdst_pkg::ELAPSED_BITS'(2 * sdst_pkg::SUBSTEP_TICKS)));
    wait_for_results();
    write_reg(sdst_pkg::REG_FORCE, 32'd1);
    send_word(word_of(sdst_pkg::CMD_ACTIVATE, Q_NEG_MAX, '0));
    send_word(word_of(sdst_pkg::CMD_UPDATE, Q_POS_MAX,
                      sdst_pkg::ELAPSED_BITS'(sdst_pkg::SUBSTEP_TICKS)));
    send_word(word_of(sdst_pkg::CMD_ACTIVATE, Q_POS_MAX, '0));
    send_word(word_of(sdst_pkg::CMD_ZERO_VEL, '0, '0));
    send_word(word_of(sdst_pkg::CMD_UPDATE, Q_NEG_MAX,
                      sdst_pkg::ELAPSED_BITS'(3 * sdst_pkg::SUBSTEP_TICKS + 17)));
    send_word(word_of(sdst_pkg::CMD_ACTIVATE, '0, '0));
    // scaled target saturates the destination
    wait_for_results();
    write_reg(sdst_pkg::REG_SCALE, Q_NEG_MAX);
    send_word(word_of(sdst_pkg::CMD_UPDATE, Q_NEG_MAX,
                      sdst_pkg::ELAPSED_BITS'(sdst_pkg::SUBSTEP_TICKS)));
    send_word(word_of(sdst_pkg::CMD_UPDATE, Q_POS_MAX, 20'd100));
    send_word(word_of(CMD_UNUSED, '0, '0));
  endtask

  // Register extremes, including data bits above the spring, damping and force widths
  task automatic test_register_extremes();
    apply_setting('0, '0, Q_ONE, 32'd1);
    run_words(EXTREME_WORDS, $urandom);
    apply_setting(32'h07ffffff, 32'h007fffff, Q_POS_MAX, 32'd0);
    run_words(EXTREME_WORDS, $urandom);
    apply_setting(32'hffffffff, 32'hffffffff, Q_NEG_MAX, 32'hfffffffe);
    run_words(EXTREME_WORDS, $urandom);
    apply_setting(32'd67108864, 32'd4194304, '0, 32'd1);
    run_words(EXTREME_WORDS, $urandom);
    apply_setting(32'd655360, 32'd414487, -Q_ONE, 32'd1);
    run_words(EXTREME_WORDS, $urandom);
  endtask

  // Phases of tracking a setpoint, mostly with damping set to 2*sqrt(k)
  task automatic test_random_tracking();
    logic [sdst_pkg::CFG_W-1:0]      k_val;
    logic [sdst_pkg::CFG_W-1:0]      d_val;
    logic [sdst_pkg::CFG_W-1:0]      scale_val;
    logic signed [sdst_pkg::Q_W-1:0] setpoint;
    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      case ($urandom_range(0, 7))
        0: begin k_val = 32'd655360;   d_val = 32'd414487;  end
        1: begin k_val = 32'd65536;    d_val = 32'd131072;  end
        2: begin k_val = 32'd6553600;  d_val = 32'd1310720; end
        3: begin k_val = 32'd26214400; d_val = 32'd2621440; end
        4: begin k_val = 32'h07ffffff; d_val = 32'd5931642; end
        5: begin k_val = $urandom;     d_val = $urandom;    end
        6: begin
          k_val = $urandom_range(0, 67108864);
          d_val = $urandom_range(0, 4194304);
        end
        default: begin k_val = '0; d_val = $urandom_range(0, 4194304); end
      endcase
      case ($urandom_range(0, 7))
        0: scale_val = Q_ONE;
        1: scale_val = -Q_ONE;
        2: scale_val = 32'h00008000;
        3: scale_val = $urandom;
        4: scale_val = Q_POS_MAX;
        5: scale_val = Q_NEG_MAX;
        6: scale_val = '0;
        default: scale_val = 2 * Q_ONE;
      endcase
      apply_setting(k_val, d_val, scale_val, $urandom);
      setpoint = ($urandom_range(0, 3) == 0) ? $urandom
                 : sdst_pkg::Q_W'($urandom_range(0, 131072000)) - 32'd65536000;
      run_words(PHASE_WORDS, setpoint);
    end
  endtask

  // Hold off the result side while words keep coming, then drain
  task automatic test_output_backpressure();
    tracker_word_t w;
    wait_for_results();
    hold_request = LONG_HOLD;
    burst_left = 100;
    repeat (PRESSURE_WORDS) begin
      w = random_word($urandom);
      w.elapsed = sdst_pkg::ELAPSED_BITS'($urandom_range(0, 3000));
      send_word(w);
    end
    wait_for_results();
  endtask

  initial begin
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    req_ch.valid = 1'b0;
    req_ch.cmd = '0;
    req_ch.target = '0;
    req_ch.elapsed = '0;
    model_k = sdst_pkg::SPRING_RST;
    model_d = sdst_pkg::DAMP_RST;
    model_scale = sdst_pkg::SCALE_RST;
    model_force = 1'b0;
    model_pos = '0;
    model_vel = '0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_directed_words();
    test_register_extremes();
    test_random_tracking();
    test_output_backpressure();

    // let any stray result show up before judging
    wait_for_results();
    repeat (UPDATE_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // Result side: switch between stall modes, honor a requested long hold
  initial begin
    rsp_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_request > 0) begin
        hold_left = hold_request;
        hold_request = 0;
      end
      if (mode_left == 0) begin
        stall_mode = rx_mode_t'($urandom_range(0, 3));
        stall_pattern = 8'($urandom) | 8'h01;
        mode_left = $urandom_range(40, 400);
      end else begin
        mode_left--;
      end
      pattern_pos = (pattern_pos + 1) % 8;
      if (hold_left > 0) begin
        hold_left--;
        rsp_ch.ready <= 1'b0;
      end else begin
        case (stall_mode)
          RX_OPEN:    rsp_ch.ready <= 1'b1;
          RX_COIN:    rsp_ch.ready <= 1'($urandom_range(0, 1));
          RX_PATTERN: rsp_ch.ready <= stall_pattern[pattern_pos[2:0]];
          default:    rsp_ch.ready <= ($urandom_range(0, 7) != 0);
        endcase
      end
    end
  end

  // Compare each accepted result with the oldest expected state
  always @(posedge clk) begin
    if (!rst && rsp_ch.valid && rsp_ch.ready) begin
      if (pending_states.size() == 0) begin
        $display("%0t: result with none expected, actual position %h speed %h",
                 $time, rsp_ch.position, rsp_ch.speed);
        mismatch_count++;
      end else begin
        oldest_state = pending_states.pop_front();
        if (rsp_ch.position !== oldest_state.position) begin
          $display("%0t: position mismatch, expected %h, actual %h",
                   $time, oldest_state.position, rsp_ch.position);
          mismatch_count++;
        end
        if (rsp_ch.speed !== oldest_state.speed) begin
          $display("%0t: speed mismatch, expected %h, actual %h",
                   $time, oldest_state.speed, rsp_ch.speed);
          mismatch_count++;
        end
      end
    end
  end

  // Give up once the cycle count passes CYCLE_LIMIT
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

endmodule

[spring_damper_substep_tracker.f]
sv/sdst_pkg.sv
sv/sdst_req_if.sv
sv/sdst_rsp_if.sv
sv/sdst_mul.sv
sv/spring_damper_substep_tracker.sv
test/tb_spring_damper_substep_tracker.sv
